FILE: rtl/ppau_pkg.sv
`timescale 1ns / 1ps
// Package for the paged pointer address unit.
// Request, result and pointer write-back types and shared constants; no dependencies.
package ppau_pkg;

  localparam int unsigned PTR_WIDTH            = 16;
  localparam int unsigned NUM_PTRS             = 4;
  localparam int unsigned PAGE_OFFSET_BITS_DEF = 12;

  localparam logic       CMD_FETCH   = 1'b0;
  localparam logic       CMD_OPERAND = 1'b1;
  localparam logic [7:0] ESCAPE_DISP = 8'h80;
  localparam logic [1:0] PTR_PC      = 2'd0;

  typedef logic [NUM_PTRS-1:0][PTR_WIDTH-1:0] ptr_array_t;

  typedef struct packed {
    logic              command;
    logic              auto_index;
    logic [1:0]        pointer_select;
    logic signed [7:0] displacement;
    logic signed [7:0] extension_value;
  } req_t;

  typedef struct packed {
    logic [PTR_WIDTH-1:0] address;
    logic                 is_immediate;
    logic [7:0]           immediate_value;
  } rsp_t;

  typedef struct packed {
    logic                 en;
    logic [1:0]           sel;
    logic [PTR_WIDTH-1:0] value;
  } ptr_wb_t;

endpackage

FILE: rtl/ppau_addr_gen.sv
`timescale 1ns / 1ps
// Effective address generation for one request: fetch, indexed, auto-indexed, immediate.
// Depends on ppau_pkg.
module ppau_addr_gen #(
  parameter int unsigned PAGE_OFFSET_BITS = ppau_pkg::PAGE_OFFSET_BITS_DEF
) (
  input  ppau_pkg::req_t       req,
  input  ppau_pkg::ptr_array_t ptrs,
  output ppau_pkg::rsp_t       rsp,
  output ppau_pkg::ptr_wb_t    wb
);
  import ppau_pkg::*;

  localparam logic [PTR_WIDTH-1:0] OFS_MASK =
    PTR_WIDTH'((32'd1 << PAGE_OFFSET_BITS) - 32'd1);

  function automatic logic [PTR_WIDTH-1:0] paged_add(input logic [PTR_WIDTH-1:0] from_ptr,
                                                     input logic [PTR_WIDTH-1:0] step_by);
    logic [PTR_WIDTH-1:0] sum;
    sum = from_ptr + step_by;
    return (from_ptr & ~OFS_MASK) | (sum & OFS_MASK);
  endfunction

  logic [7:0]           eff_disp;
  logic [PTR_WIDTH-1:0] delta;
  logic [PTR_WIDTH-1:0] base;
  logic [PTR_WIDTH-1:0] moved;
  logic [PTR_WIDTH-1:0] pc_next;

  assign eff_disp = (req.displacement == ESCAPE_DISP) ? req.extension_value : req.displacement;
  assign delta    = {{(PTR_WIDTH-8){eff_disp[7]}}, eff_disp};
  assign base     = ptrs[req.pointer_select];
  assign moved    = paged_add(base, delta);
  assign pc_next  = paged_add(ptrs[PTR_PC], PTR_WIDTH'(1));

  always_comb begin
    rsp = '0;
    wb  = '0;
    if (req.command == CMD_FETCH) begin
      rsp.address = pc_next;
      wb.en       = 1'b1;
      wb.sel      = PTR_PC;
      wb.value    = pc_next;
    end else if (req.auto_index && (req.pointer_select == PTR_PC)) begin
      rsp.is_immediate    = 1'b1;
      rsp.immediate_value = req.displacement;
    end else if (!req.auto_index) begin
      rsp.address = moved;
    end else begin
      wb.en       = 1'b1;
      wb.sel      = req.pointer_select;
      wb.value    = moved;
      rsp.address = eff_disp[7] ? moved : base;
    end
  end

endmodule

FILE: rtl/paged_pointer_address_unit.sv
`timescale 1ns / 1ps
// Top level of the paged pointer address unit: input register, pointer file, result register.
// Depends on ppau_pkg and ppau_addr_gen.
//
// Usage:
//   A request (in_req) is taken on a rising edge with in_valid high and in_stall low.
//   Fetch requests advance the program counter (pointer 0) and return it as the
//   address; operand requests form an indexed or auto-indexed address from the
//   selected pointer, or return the displacement byte as immediate data.
//   The result (out_rsp) is offered on out_valid and taken when out_stall is low.
//   A taken request sits in the input register; its address is computed and its pointer
//   write-back done on the edge that moves it into the result register, and out_valid is
//   high after that edge. Throughput: one request per cycle while out_stall is low, set
//   by the two 16-bit paged adds and pointer write-back between the input and result registers.
//   While the receiver stalls, the result register holds; one further request
//   waits in the input register, after which in_stall rises.
//   Reset clears all four pointers, both valid flags, and leaves no result pending.
module paged_pointer_address_unit #(
  parameter int unsigned PAGE_OFFSET_BITS = ppau_pkg::PAGE_OFFSET_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ppau_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output ppau_pkg::rsp_t out_rsp
);
  import ppau_pkg::*;

  logic       req_valid_r;
  req_t       req_r;
  rsp_t       rsp_r;
  logic       rsp_valid_r;
  ptr_array_t ptrs_r;

  rsp_t    rsp_nxt;
  ptr_wb_t wb;
  logic    advance;
  logic    in_take;

  ppau_addr_gen #(
    .PAGE_OFFSET_BITS(PAGE_OFFSET_BITS)
  ) u_addr_gen (
    .req (req_r),
    .ptrs(ptrs_r),
    .rsp (rsp_nxt),
    .wb  (wb)
  );

  assign advance  = !rsp_valid_r || !out_stall;
  assign in_stall = req_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      rsp_valid_r <= 1'b0;
      ptrs_r      <= '0;
    end else begin
      if (in_take) begin
        req_valid_r <= 1'b1;
      end else if (advance) begin
        req_valid_r <= 1'b0;
      end
      if (advance) begin
        rsp_valid_r <= req_valid_r;
      end
      if (req_valid_r && advance && wb.en) begin
        ptrs_r[wb.sel] <= wb.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_req;
    end
    if (req_valid_r && advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = rsp_valid_r;
  assign out_rsp   = rsp_r;

endmodule

FILE: tb/paged_pointer_address_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for paged_pointer_address_unit: directed and random requests, with
// random idling on both channels; results are checked by a pointer-file scoreboard class.
// Depends on ppau_pkg and the RTL of the block.
module paged_pointer_address_unit_tb;
  import ppau_pkg::*;

  localparam int unsigned OFFSET_BITS     = 12;
  localparam int unsigned RANDOM_REQS     = 450;

  class pointer_file_model;
    logic [PTR_WIDTH-1:0] ptr_regs [NUM_PTRS];
    rsp_t                 due_rsps [$];
    int unsigned          mismatches;

    function new();
      foreach (ptr_regs[i]) ptr_regs[i] = '0;
      mismatches = 0;
    endfunction

    function logic [PTR_WIDTH-1:0] page_step(logic [PTR_WIDTH-1:0] base,
                                             logic [PTR_WIDTH-1:0] delta);
      logic [PTR_WIDTH-1:0] low_mask;
      low_mask = PTR_WIDTH'((1 << OFFSET_BITS) - 1);
      return (base & ~low_mask) | ((base + delta) & low_mask);
    endfunction

    function void take_request(req_t r);
      rsp_t                 want;
      logic [7:0]           eff;
      logic [PTR_WIDTH-1:0] moved;
      want = '0;
      if (r.command == CMD_FETCH) begin
        ptr_regs[PTR_PC] = page_step(ptr_regs[PTR_PC], 16'd1);
        want.address = ptr_regs[PTR_PC];
      end else if (r.auto_index && r.pointer_select == PTR_PC) begin
        want.is_immediate    = 1'b1;
        want.immediate_value = r.displacement;
      end else begin
        // substitute the extension byte for the escape displacement
        eff   = (r.displacement == ESCAPE_DISP) ? r.extension_value : r.displacement;
        moved = page_step(ptr_regs[r.pointer_select], {{8{eff[7]}}, eff});
        if (!r.auto_index) begin
          want.address = moved;
        end else if (eff[7]) begin
          ptr_regs[r.pointer_select] = moved;
          want.address = moved;
        end else begin
          want.address = ptr_regs[r.pointer_select];
          ptr_regs[r.pointer_select] = moved;
        end
      end
      due_rsps.push_back(want);
    endfunction

    function void match_result(rsp_t got);
      rsp_t want;
      if (due_rsps.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request outstanding: expected none, actual %h",
                 $time, got);
        return;
      end
      want = due_rsps.pop_front();
      if (got.address !== want.address) begin
        mismatches++;
        $display("%0t: address mismatch: expected %h, actual %h",
                 $time, want.address, got.address);
      end
      if (got.is_immediate !== want.is_immediate) begin
        mismatches++;
        $display("%0t: is_immediate mismatch: expected %b, actual %b",
                 $time, want.is_immediate, got.is_immediate);
      end
      if (got.immediate_value !== want.immediate_value) begin
        mismatches++;
        $display("%0t: immediate_value mismatch: expected %h, actual %h",
                 $time, want.immediate_value, got.immediate_value);
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  req_t in_req    = '0;
  logic in_stall;
  logic out_valid;
  rsp_t out_rsp;
  logic quiet     = 1'b0;

  pointer_file_model ptr_model;

  paged_pointer_address_unit #(
    .PAGE_OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  always #5 clk = ~clk;

  function automatic req_t make_req(logic cmd, logic autoi, logic [1:0] sel,
                                    logic [7:0] disp, logic [7:0] ext);
    req_t r;
    r.command         = cmd;
    r.auto_index      = autoi;
    r.pointer_select  = sel;
    r.displacement    = disp;
    r.extension_value = ext;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return ESCAPE_DISP;
      1: return 8'h7f;
      2: return 8'hff;
      3: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic req_t random_req();
    return make_req(($urandom_range(0, 99) < 20) ? CMD_FETCH : CMD_OPERAND,
                    1'($urandom), 2'($urandom), pick_byte(), pick_byte());
  endfunction

  task automatic send_req(input req_t r);
    if (!quiet && $urandom_range(0, 99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    ptr_model.take_request(r);
  endtask

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 10);
    if (rst_n && out_valid && !out_stall) ptr_model.match_result(out_rsp);
  end

  initial begin
    int unsigned waited;
    ptr_model = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_req(make_req(CMD_FETCH,   1'b0, 2'd0, 8'h00, 8'h00));
    send_req(make_req(CMD_FETCH,   1'b0, 2'd0, 8'h00, 8'h00));
    send_req(make_req(CMD_OPERAND, 1'b0, 2'd1, 8'h7f, 8'h00));
    send_req(make_req(CMD_OPERAND, 1'b0, 2'd1, 8'hff, 8'h00));
    send_req(make_req(CMD_OPERAND, 1'b1, 2'd1, 8'hff, 8'h00));
    send_req(make_req(CMD_OPERAND, 1'b1, 2'd1, 8'h01, 8'h00));
    send_req(make_req(CMD_OPERAND, 1'b1, 2'd2, 8'h7f, 8'h00));
    send_req(make_req(CMD_OPERAND, 1'b1, 2'd2, ESCAPE_DISP, 8'h80));
    send_req(make_req(CMD_OPERAND, 1'b0, 2'd2, ESCAPE_DISP, 8'h7f));
    send_req(make_req(CMD_OPERAND, 1'b1, 2'd3, ESCAPE_DISP, 8'h05));
    send_req(make_req(CMD_OPERAND, 1'b1, 2'd3, 8'h00, 8'hff));
    send_req(make_req(CMD_OPERAND, 1'b1, PTR_PC, ESCAPE_DISP, 8'h03));
    send_req(make_req(CMD_OPERAND, 1'b1, PTR_PC, 8'h7f, 8'h80));
    send_req(make_req(CMD_OPERAND, 1'b1, PTR_PC, 8'h00, 8'h7f));
    send_req(make_req(CMD_OPERAND, 1'b1, PTR_PC, 8'hff, 8'h00));
    send_req(make_req(CMD_OPERAND, 1'b0, PTR_PC, ESCAPE_DISP, 8'h80));
    send_req(make_req(CMD_OPERAND, 1'b0, PTR_PC, 8'h7f, 8'hff));
    send_req(make_req(CMD_FETCH,   1'b1, 2'd3, ESCAPE_DISP, 8'hff));
    send_req(make_req(CMD_OPERAND, 1'b1, 2'd3, ESCAPE_DISP, 8'hff));
    send_req(make_req(CMD_OPERAND, 1'b0, 2'd3, 8'h00, 8'hff));

    for (int unsigned i = 0; i < RANDOM_REQS; i++) begin
      quiet = (i >= 150 && i < 300);
      send_req(random_req());
    end
    in_valid <= 1'b0;

    waited = 0;
    while (ptr_model.due_rsps.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);

    if (ptr_model.mismatches == 0 && ptr_model.due_rsps.size() == 0) begin
      $display("** paged_pointer_address_unit: PASSED **");
    end else begin
      $display("** paged_pointer_address_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** paged_pointer_address_unit: FAILED **");
    $finish;
  end

endmodule
